[rtl/rtct_pkg.sv]
`timescale 1ns / 1ps

package rtct_pkg;

	localparam int ROW_COUNT_DEF = 1024;
	localparam int ROW_W         = 10;
	localparam int TXN_W         = 8;
	localparam int TS_W          = 64;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [2:0] ACT_READ    = 3'd0;
	localparam logic [2:0] ACT_LOCK    = 3'd1;
	localparam logic [2:0] ACT_INSTALL = 3'd2;
	localparam logic [2:0] ACT_RENEW   = 3'd3;
	localparam logic [2:0] ACT_RELEASE = 3'd4;
	localparam logic [2:0] ACT_DELETE  = 3'd5;

	typedef struct packed {
		logic [2:0]       action;
		logic [ROW_W-1:0] row;
		logic [TXN_W-1:0] txn_id;
		logic [TS_W-1:0]  stamp;
		logic [TS_W-1:0]  check_wts;
		logic [TS_W-1:0]  check_rts;
	} req_t;

	typedef struct packed {
		logic            ok;
		logic [TS_W-1:0] out_wts;
		logic [TS_W-1:0] out_rts;
	} rsp_t;

	// queued item, classified by the front end
	typedef struct packed {
		logic             in_range;
		logic [2:0]       action;
		logic [ROW_W-1:0] row;
		logic [TXN_W-1:0] txn_id;
		logic [TS_W-1:0]  stamp;
		logic [TS_W-1:0]  check_wts;
		logic [TS_W-1:0]  check_rts;
	} q_entry_t;

	typedef struct packed {
		logic [TS_W-1:0]  wts;
		logic [TS_W-1:0]  rts;
		logic             locked;
		logic [TXN_W-1:0] owner;
		logic [TS_W-1:0]  pending;
		logic             deleted;
		logic [TS_W-1:0]  del_time;
	} row_rec_t;

	typedef struct packed {
		logic     head_valid;
		q_entry_t head;
	} fr_stat_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_stat_t;

endpackage

[rtl/rtct_ram.sv]
`timescale 1ns / 1ps

module rtct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/rtct_front.sv]
`timescale 1ns / 1ps

module rtct_front #(
	parameter int ROW_COUNT = rtct_pkg::ROW_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rtct_pkg::req_t    req,
	output logic              busy,
	input  rtct_pkg::bk_stat_t bk_stat,
	output rtct_pkg::fr_stat_t fr_stat
);

	localparam int QD  = rtct_pkg::QUEUE_DEPTH;
	localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW  = $clog2(QD + 1);

	rtct_pkg::q_entry_t queue_q [QD];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               full;
	logic               accept;
	rtct_pkg::q_entry_t entry;

	assign full   = (count_q == CW'(QD));
	assign busy   = bk_stat.clearing || full;
	assign accept = start && !busy;

	always_comb begin
		entry.in_range  = (32'(req.row) < 32'(ROW_COUNT));
		entry.action    = req.action;
		entry.row       = req.row;
		entry.txn_id    = req.txn_id;
		entry.stamp     = req.stamp;
		entry.check_wts = req.check_wts;
		entry.check_rts = req.check_rts;
	end

	assign fr_stat.head_valid = (count_q != '0);
	assign fr_stat.head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (bk_stat.pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({accept, bk_stat.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/rtct_back.sv]
`timescale 1ns / 1ps

module rtct_back #(
	parameter int ROW_COUNT = rtct_pkg::ROW_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rtct_pkg::fr_stat_t fr_stat,
	output rtct_pkg::bk_stat_t bk_stat,
	output logic               done,
	output rtct_pkg::rsp_t     rsp
);

	localparam int AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int REC_W = $bits(rtct_pkg::row_rec_t);

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} bk_state_t;

	bk_state_t          state_q;
	logic [AW-1:0]      clr_cnt_q;
	rtct_pkg::q_entry_t item_q;
	logic               done_q;
	rtct_pkg::rsp_t     rsp_q;

	logic               pop;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [REC_W-1:0]   ram_wdata;
	logic [REC_W-1:0]   ram_rdata;
	rtct_pkg::row_rec_t cur;
	rtct_pkg::row_rec_t nxt;
	logic               ok;

	assign pop = (state_q == B_IDLE) && fr_stat.head_valid;

	assign bk_stat.clearing = (state_q == B_CLEAR);
	assign bk_stat.pop      = pop;

	assign cur = rtct_pkg::row_rec_t'(ram_rdata);

	always_comb begin
		nxt = cur;
		ok  = 1'b0;
		unique case (item_q.action)
			rtct_pkg::ACT_READ: begin
				if (!(cur.locked && item_q.stamp > cur.pending)) begin
					ok = 1'b1;
					if (item_q.stamp > cur.rts) begin
						nxt.rts = item_q.stamp;
					end
				end
			end
			rtct_pkg::ACT_LOCK: begin
				if (item_q.stamp > cur.rts && (!cur.locked || cur.owner == item_q.txn_id)) begin
					ok          = 1'b1;
					nxt.locked  = 1'b1;
					nxt.owner   = item_q.txn_id;
					nxt.pending = item_q.stamp;
				end
			end
			rtct_pkg::ACT_INSTALL: begin
				ok      = 1'b1;
				nxt.wts = item_q.stamp;
				nxt.rts = item_q.stamp;
			end
			rtct_pkg::ACT_RENEW: begin
				priority if (item_q.check_wts != cur.wts) begin
					ok = 1'b0;
				end else if (cur.deleted) begin
					ok = (item_q.check_rts < cur.del_time);
				end else if (cur.locked) begin
					ok = 1'b0;
				end else begin
					ok = 1'b1;
					if (item_q.check_rts > cur.rts) begin
						nxt.rts = item_q.check_rts;
					end
				end
			end
			rtct_pkg::ACT_RELEASE: begin
				ok = 1'b1;
				if (cur.locked && cur.owner == item_q.txn_id) begin
					nxt.locked = 1'b0;
				end
			end
			rtct_pkg::ACT_DELETE: begin
				ok           = 1'b1;
				nxt.deleted  = 1'b1;
				nxt.del_time = item_q.stamp;
			end
			default: ok = 1'b0;
		endcase
	end

	// reads only in B_IDLE, writes only in B_CLEAR/B_EXEC
	always_comb begin
		ram_we    = (state_q == B_CLEAR) || (state_q == B_EXEC);
		ram_waddr = (state_q == B_CLEAR) ? clr_cnt_q : AW'(item_q.row);
		ram_wdata = (state_q == B_CLEAR) ? '0 : REC_W'(nxt);
	end

	rtct_ram #(
		.WIDTH (REC_W),
		.DEPTH (ROW_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (AW'(fr_stat.head.row)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_cnt_q <= '0;
			item_q    <= '0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					if (clr_cnt_q == AW'(ROW_COUNT - 1)) begin
						state_q <= B_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				B_IDLE: begin
					if (pop) begin
						item_q <= fr_stat.head;
						if (fr_stat.head.in_range) begin
							state_q <= B_EXEC;
						end else begin
							done_q <= 1'b1;
							rsp_q  <= '0;
						end
					end
				end
				B_EXEC: begin
					done_q        <= 1'b1;
					rsp_q.ok      <= ok;
					rsp_q.out_wts <= nxt.wts;
					rsp_q.out_rts <= nxt.rts;
					state_q       <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[rtl/row_timestamp_concurrency_table_top.sv]
`timescale 1ns / 1ps
// Flow: an accepted item is queued; when the back end is idle it pops the item and
// reads its row, then updates it and raises done; a queued item waits its turn.
// A 2-entry queue decouples start from the RAM. The back end pops no item until
// the row read-modify-write is done; an out-of-range row is answered from B_IDLE.
// Reset: a clearing pass zeroes every row; busy is high meanwhile.
// The receiver cannot stall: done is high for exactly one cycle with each new rsp.

module row_timestamp_concurrency_table_top #(
	parameter int ROW_COUNT = rtct_pkg::ROW_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rtct_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output rtct_pkg::rsp_t rsp
);

	rtct_pkg::fr_stat_t fr_stat;
	rtct_pkg::bk_stat_t bk_stat;

	rtct_front #(
		.ROW_COUNT (ROW_COUNT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.bk_stat (bk_stat),
		.fr_stat (fr_stat)
	);

	rtct_back #(
		.ROW_COUNT (ROW_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.fr_stat (fr_stat),
		.bk_stat (bk_stat),
		.done    (done),
		.rsp     (rsp)
	);

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> busy)
		else $error("item accepted during clearing pass");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> fr_stat.head_valid)
		else $error("pop from empty queue");

	a_clear_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bk_stat.clearing) |-> !done)
		else $error("result at end of clearing pass");

	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_stat.pop && fr_stat.head.in_range) |=> !bk_stat.pop)
		else $error("row read issued during update");

endmodule
